// ===== hdl/token_ring_termination_detect_top_defines.svh =====
// Assertion macros used by the top module of the termination detector.
`ifndef TOKEN_RING_TERMINATION_DETECT_TOP_DEFINES_SVH
`define TOKEN_RING_TERMINATION_DETECT_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define TRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// ===== hdl/trd_pkg.sv =====
package trd_pkg;

   typedef struct packed {
      logic valid;
      logic black;
   } pass_type;

   typedef struct packed {
      logic go;
      logic work;
      logic finish;
   } step_type;

   localparam int unsigned NODE_W   = 6;
   localparam int unsigned ACTIVE_W = 7;

endpackage

// ===== hdl/trd_cell.sv =====
module trd_cell #(
   parameter bit IS_MASTER = 1'b0
) (
   input  logic              clock,
   input  logic              reset,
   input  trd_pkg::step_type step,
   input  logic              hit,
   input  trd_pkg::pass_type pass_in,
   output logic              holds,
   output logic              taint,
   output trd_pkg::pass_type pass_out
);

   logic holds_ff, holds_in;
   logic node_black_ff, node_black_in;
   logic token_black_ff, token_black_in;
   logic turn;
   logic node_black_eff;

   always_comb begin
      turn           = step.go & hit & holds_ff;
      node_black_eff = node_black_ff | (step.go & hit & step.work);
      taint          = node_black_eff | token_black_ff;
      holds          = holds_ff;
   end

   // The master's token always leaves white; a passing cell also clears its marks.
   always_comb begin
      pass_out.valid = turn & ~step.finish;
      pass_out.black = turn & ~step.finish & taint & ~IS_MASTER;
   end

   always_comb begin
      holds_in       = holds_ff;
      node_black_in  = node_black_eff;
      token_black_in = token_black_ff;
      if (turn) begin
         node_black_in  = 1'b0;
         token_black_in = 1'b0;
         if (!step.finish) begin
            holds_in = 1'b0;
         end
      end
      if (pass_in.valid) begin
         holds_in       = 1'b1;
         token_black_in = pass_in.black;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holds_ff       <= IS_MASTER;
         node_black_ff  <= 1'b1;
         token_black_ff <= 1'b0;
      end else begin
         holds_ff       <= holds_in;
         node_black_ff  <= node_black_in;
         token_black_ff <= token_black_in;
      end
   end

endmodule

// ===== hdl/token_ring_termination_detect_top.sv =====
// Termination detector for a ring of worker nodes passing a coloured token.
// Input channel (req_): one word per idle report, carrying the node's ring
// position and a flag saying whether it did work since its last report.
// Result channel (rsp_): one word per report, giving the sticky done flag,
// whether the token moved, its colour and whether the report was rejected.
// Configuration (csr_): csr_wr_en writes the active node count; write it only
// while idle (not enforced by the block). The result word appears in the cycle
// after acceptance. One report is taken per cycle unless req_stall is high;
// each node is a cell of a ring; the token moves to the next cell in that cycle.
// While the receiver stalls a waiting result, req_stall is raised and no
// report is taken; the result word holds until it is taken.
// Reset empties the output register, gives the token to node 0, marks every
// node black, clears the termination flag and sets the active count to 64.
`include "token_ring_termination_detect_top_defines.svh"

module token_ring_termination_detect_top #(
   parameter int unsigned MAX_NODES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [5:0] req_node_index,
   input  logic       req_work_happened,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_global_done,
   output logic       rsp_token_moved,
   output logic       rsp_token_sent_black,
   output logic       rsp_report_error,
   input  logic       csr_wr_en,
   input  logic [6:0] csr_wr_data
);

   localparam int unsigned CMP_W =
      ($clog2(MAX_NODES + 1) > trd_pkg::ACTIVE_W) ? $clog2(MAX_NODES + 1) : trd_pkg::ACTIVE_W;

   logic [trd_pkg::ACTIVE_W-1:0] active_ff, active_in;
   logic [trd_pkg::ACTIVE_W-1:0] ring_count;
   logic                         prev_clean_ff, prev_clean_in;
   logic                         terminated_ff, terminated_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         done_ff, moved_ff, black_ff, error_ff;

   logic             req_accept;
   logic             node_error;
   logic             failed;
   logic             master_turn;
   logic             finish;
   logic             moved;
   logic             sent_black;
   trd_pkg::step_type step;

   logic [MAX_NODES-1:0] hit_vec;
   logic [MAX_NODES-1:0] last_vec;
   logic [MAX_NODES-1:0] holds_vec;
   logic [MAX_NODES-1:0] taint_vec;
   logic [MAX_NODES-1:0] pass_valid_vec;
   logic [MAX_NODES-1:0] pass_black_vec;
   trd_pkg::pass_type    pass_out [MAX_NODES];
   trd_pkg::pass_type    pass_in  [MAX_NODES];
   trd_pkg::pass_type    wrap_pass;

   always_comb begin
      active_in = csr_wr_en ? csr_wr_data : active_ff;
      priority if (active_ff == '0) begin
         ring_count = trd_pkg::ACTIVE_W'(1);
      end else if (CMP_W'(active_ff) > CMP_W'(MAX_NODES)) begin
         ring_count = trd_pkg::ACTIVE_W'(MAX_NODES);
      end else begin
         ring_count = active_ff;
      end
   end

   always_comb begin
      req_stall  = rsp_valid_ff & rsp_stall;
      req_accept = req_valid & ~req_stall;
      node_error = ({1'b0, req_node_index} >= ring_count)
                 | (req_work_happened & terminated_ff);
   end

   always_comb begin
      failed        = taint_vec[0];
      master_turn   = req_accept & ~node_error & ~terminated_ff & hit_vec[0] & holds_vec[0];
      finish        = master_turn & prev_clean_ff & ~failed;
      step.go       = req_accept & ~node_error & ~terminated_ff;
      step.work     = req_work_happened;
      step.finish   = finish;
      prev_clean_in = (master_turn & ~finish) ? ~failed : prev_clean_ff;
      terminated_in = terminated_ff | finish;
      moved         = |pass_valid_vec;
      sent_black    = |pass_black_vec;
      wrap_pass.valid = |(pass_valid_vec & last_vec);
      wrap_pass.black = |(pass_black_vec & last_vec);
   end

   for (genvar i = 0; i < MAX_NODES; i++) begin : g_ring
      assign hit_vec[i]        = (32'(req_node_index) == 32'(i));
      assign last_vec[i]       = (32'(ring_count) - 32'd1 == 32'(i));
      assign pass_valid_vec[i] = pass_out[i].valid;
      assign pass_black_vec[i] = pass_out[i].black;

      if (i == 0) begin : g_wrap
         assign pass_in[i] = wrap_pass;
      end else begin : g_link
         assign pass_in[i].valid = pass_out[i-1].valid & ~last_vec[i-1];
         assign pass_in[i].black = pass_out[i-1].black & ~last_vec[i-1];
      end

      trd_cell #(
         .IS_MASTER (i == 0)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .step     (step),
         .hit      (hit_vec[i]),
         .pass_in  (pass_in[i]),
         .holds    (holds_vec[i]),
         .taint    (taint_vec[i]),
         .pass_out (pass_out[i])
      );
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= trd_pkg::ACTIVE_W'(64);
         prev_clean_ff <= 1'b1;
         terminated_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         active_ff     <= active_in;
         prev_clean_ff <= prev_clean_in;
         terminated_ff <= terminated_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         done_ff  <= terminated_in;
         moved_ff <= moved;
         black_ff <= sent_black;
         error_ff <= node_error;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_global_done      = done_ff;
   assign rsp_token_moved      = moved_ff;
   assign rsp_token_sent_black = black_ff;
   assign rsp_report_error     = error_ff;

   `TRD_ASSERT_NOW(a_single_token, clock, reset, 1'b1, $onehot(holds_vec))
   `TRD_ASSERT_NEXT(a_done_sticky, clock, reset, terminated_ff, terminated_ff)
   `TRD_ASSERT_NEXT(a_late_work_rejected, clock, reset,
      req_accept && terminated_ff && req_work_happened, rsp_valid && rsp_report_error)
   `TRD_ASSERT_NOW(a_no_move_when_done, clock, reset, rsp_valid,
      !(rsp_token_moved && rsp_global_done))

endmodule

// ===== tb/token_ring_termination_detect_top_test.sv =====
module token_ring_termination_detect_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic done;
      logic moved;
      logic black;
      logic err;
   } report_outcome_type;

   typedef enum logic [1:0] {
      ROW_REPORT,
      ROW_HOLDER,
      ROW_HOME,
      ROW_CONFIG
   } row_kind_type;

   typedef struct packed {
      row_kind_type                 kind;
      logic [trd_pkg::ACTIVE_W-1:0] value;
      logic [trd_pkg::NODE_W-1:0]   node;
      logic                         work;
      logic                         typed;
      report_outcome_type           outcome;
   } directed_row_type;

   // Outcome bits are done, moved, black, error.
   localparam directed_row_type OPENING_ROWS [23] = '{
      '{ROW_REPORT, 7'd0,   6'd0,  1'b0, 1'b1, 4'b0100},
      '{ROW_REPORT, 7'd0,   6'd63, 1'b1, 1'b0, 4'b0000},
      '{ROW_REPORT, 7'd0,   6'd1,  1'b0, 1'b0, 4'b0000},
      '{ROW_CONFIG, 7'd2,   6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_REPORT, 7'd0,   6'd2,  1'b0, 1'b1, 4'b0001},
      '{ROW_REPORT, 7'd0,   6'd63, 1'b1, 1'b1, 4'b0001},
      '{ROW_CONFIG, 7'd127, 6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_REPORT, 7'd0,   6'd2,  1'b1, 1'b0, 4'b0000},
      '{ROW_CONFIG, 7'd0,   6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_REPORT, 7'd0,   6'd3,  1'b0, 1'b1, 4'b0001},
      '{ROW_REPORT, 7'd0,   6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_CONFIG, 7'd4,   6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_REPORT, 7'd0,   6'd3,  1'b0, 1'b0, 4'b0000},
      '{ROW_CONFIG, 7'd1,   6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_REPORT, 7'd0,   6'd0,  1'b1, 1'b0, 4'b0000},
      '{ROW_REPORT, 7'd0,   6'd1,  1'b0, 1'b1, 4'b0001},
      '{ROW_CONFIG, 7'd4,   6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_REPORT, 7'd0,   6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_HOLDER, 7'd0,   6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_HOLDER, 7'd0,   6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_HOLDER, 7'd0,   6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_HOLDER, 7'd0,   6'd0,  1'b1, 1'b0, 4'b0000},
      '{ROW_HOLDER, 7'd0,   6'd0,  1'b1, 1'b0, 4'b0000}
   };

   // Termination is sticky and reset comes only once, so these rows run last.
   localparam directed_row_type CLOSING_ROWS [12] = '{
      '{ROW_HOME,   7'd0,   6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_CONFIG, 7'd1,   6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_REPORT, 7'd0,   6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_REPORT, 7'd0,   6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_REPORT, 7'd0,   6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_REPORT, 7'd0,   6'd0,  1'b0, 1'b1, 4'b1000},
      '{ROW_REPORT, 7'd0,   6'd0,  1'b1, 1'b1, 4'b1001},
      '{ROW_REPORT, 7'd0,   6'd5,  1'b0, 1'b1, 4'b1001},
      '{ROW_CONFIG, 7'd64,  6'd0,  1'b0, 1'b0, 4'b0000},
      '{ROW_REPORT, 7'd0,   6'd63, 1'b1, 1'b1, 4'b1001},
      '{ROW_REPORT, 7'd0,   6'd63, 1'b0, 1'b1, 4'b1000},
      '{ROW_REPORT, 7'd0,   6'd0,  1'b0, 1'b1, 4'b1000}
   };

   localparam logic [trd_pkg::ACTIVE_W-1:0] RING_SETTINGS [8] = '{
      7'd64, 7'd3, 7'd1, 7'd127, 7'd0, 7'd2, 7'd40, 7'd100
   };

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [trd_pkg::NODE_W-1:0]   req_node_index = '0;
   logic                         req_work_happened = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic                         rsp_global_done;
   logic                         rsp_token_moved;
   logic                         rsp_token_sent_black;
   logic                         rsp_report_error;
   logic                         csr_wr_en = 1'b0;
   logic [trd_pkg::ACTIVE_W-1:0] csr_wr_data = '0;

   logic [63:0]                  token_at;
   logic [63:0]                  token_dark;
   logic [63:0]                  node_dark;
   logic                         prev_clean;
   logic                         finished;
   logic [trd_pkg::ACTIVE_W-1:0] active_reg;

   report_outcome_type  pending_outcomes [$];
   int                  error_count = 0;
   int                  sender_gap_pct = 0;
   int                  receiver_stall_pct = 0;

   token_ring_termination_detect_top u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_node_index       (req_node_index),
      .req_work_happened    (req_work_happened),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_global_done      (rsp_global_done),
      .rsp_token_moved      (rsp_token_moved),
      .rsp_token_sent_black (rsp_token_sent_black),
      .rsp_report_error     (rsp_report_error),
      .csr_wr_en            (csr_wr_en),
      .csr_wr_data          (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int ring_count();
      int n;
      n = int'(active_reg);
      if (n == 0) n = 1;
      if (n > 64) n = 64;
      return n;
   endfunction

   function automatic logic [trd_pkg::NODE_W-1:0] token_holder();
      logic [trd_pkg::NODE_W-1:0] holder;
      holder = '0;
      for (int i = 0; i < 64; i++) begin
         if (token_at[i]) holder = trd_pkg::NODE_W'(i);
      end
      return holder;
   endfunction

   function automatic report_outcome_type judge_report(logic [trd_pkg::NODE_W-1:0] node,
                                                       logic work);
      report_outcome_type o;
      int                 count;
      int                 successor;
      logic               failed;
      logic               finish;
      logic               taint;
      o = '0;
      count = ring_count();
      finish = 1'b0;
      if (node >= count || (work && finished)) begin
         o.err = 1'b1;
      end else if (!finished) begin
         node_dark[node] = node_dark[node] | work;
         if (token_at[node]) begin
            if (node == 0) begin
               failed = token_dark[0] | node_dark[0];
               token_dark[0] = 1'b0;
               node_dark[0] = 1'b0;
               if (prev_clean && !failed) begin
                  finished = 1'b1;
                  finish = 1'b1;
               end else begin
                  prev_clean = !failed;
               end
            end
            if (!finish) begin
               successor = (int'(node) + 1) % count;
               taint = node_dark[node] | token_dark[node];
               node_dark[node] = 1'b0;
               token_dark[node] = 1'b0;
               token_at[node] = 1'b0;
               token_dark[successor] = taint;
               token_at[successor] = 1'b1;
               o.moved = 1'b1;
               o.black = taint;
            end
         end
      end
      o.done = finished;
      return o;
   endfunction

   task automatic send_report(input logic [trd_pkg::NODE_W-1:0] node, input logic work,
                              input logic typed, input report_outcome_type fixed_outcome);
      report_outcome_type predicted;
      while ($urandom_range(0, 99) < sender_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_node_index <= node;
      req_work_happened <= work;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = judge_report(node, work);
      pending_outcomes.push_back(typed ? fixed_outcome : predicted);
   endtask

   task automatic write_ring_size(input logic [trd_pkg::ACTIVE_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_reg = value;
   endtask

   task automatic bring_token_home();
      while (token_holder() != 0) send_report(token_holder(), 1'b0, 1'b0, '0);
   endtask

   task automatic run_row(input directed_row_type row);
      case (row.kind)
         ROW_CONFIG: begin
            write_ring_size(row.value);
         end
         ROW_HOME: begin
            bring_token_home();
         end
         ROW_HOLDER: begin
            send_report(token_holder(), row.work, row.typed, row.outcome);
         end
         default: begin
            send_report(row.node, row.work, row.typed, row.outcome);
         end
      endcase
   endtask

   always @(posedge clock) begin : check_results
      report_outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_outcomes.size() == 0) begin
            $error("result word arrived with no report outstanding");
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_global_done !== want.done) begin
               $error("rsp_global_done: expected %0b, got %0b", want.done, rsp_global_done);
               error_count++;
            end
            if (rsp_token_moved !== want.moved) begin
               $error("rsp_token_moved: expected %0b, got %0b", want.moved, rsp_token_moved);
               error_count++;
            end
            if (rsp_token_sent_black !== want.black) begin
               $error("rsp_token_sent_black: expected %0b, got %0b",
                      want.black, rsp_token_sent_black);
               error_count++;
            end
            if (rsp_report_error !== want.err) begin
               $error("rsp_report_error: expected %0b, got %0b", want.err, rsp_report_error);
               error_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   initial begin
      int                         phase;
      int                         count;
      int                         pick;
      int                         work_pct;
      logic [trd_pkg::NODE_W-1:0] node;
      logic                       work;
      token_at = 64'd1;
      token_dark = '0;
      node_dark = '1;
      prev_clean = 1'b1;
      finished = 1'b0;
      active_reg = 7'd64;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING_ROWS[i]) run_row(OPENING_ROWS[i]);

      for (phase = 0; phase < 8; phase++) begin
         bring_token_home();
         write_ring_size((phase == 6) ? trd_pkg::ACTIVE_W'($urandom_range(1, 64))
                                      : RING_SETTINGS[phase]);
         case (phase % 4)
            0: begin
               sender_gap_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_gap_pct = 57;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_gap_pct = 0;
               receiver_stall_pct = 57;
            end
            default: begin
               sender_gap_pct = 32;
               receiver_stall_pct = 32;
            end
         endcase
         work_pct = $urandom_range(5, 40);
         repeat (30) begin
            count = ring_count();
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               node = token_holder();
            end else if (pick < 88 || count == 64) begin
               node = trd_pkg::NODE_W'($urandom_range(0, count - 1));
            end else begin
               node = trd_pkg::NODE_W'($urandom_range(count, 63));
            end
            work = ($urandom_range(0, 99) < work_pct);
            // The master must not close a clean round here, or the ring would stop for good.
            if (!work && node == 0 && token_at[0] && prev_clean && !finished &&
                !token_dark[0] && !node_dark[0]) begin
               work = 1'b1;
            end
            send_report(node, work, 1'b0, '0);
         end
      end

      sender_gap_pct = 32;
      receiver_stall_pct = 32;
      foreach (CLOSING_ROWS[i]) run_row(CLOSING_ROWS[i]);

      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (error_count == 0) begin
         $display("token_ring_termination_detect_top_test: PASS");
      end else begin
         $display("token_ring_termination_detect_top_test: FAIL");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("token_ring_termination_detect_top_test: FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/trd_pkg.sv
hdl/trd_cell.sv
hdl/token_ring_termination_detect_top.sv
tb/token_ring_termination_detect_top_test.sv
